// ===== rtl/rcu_pkg.sv =====
// Shared types, constants and digit helpers of the radix converter.
// Used by every module of the block but rcu_ram; depends on nothing.
package rcu_pkg;

    localparam int VAL_W       = 64;             // accumulator width
    localparam int CHAR_W      = 8;
    localparam int BASE_W      = 5;
    localparam int ST_W        = 2;
    localparam int LEN_W       = 7;              // holds a length up to 64
    localparam int DIG_W       = 4;
    localparam int DIG_DEPTH   = 64;             // enough digits for 64 bits in base 2
    localparam int DIG_AW      = $clog2(DIG_DEPTH);
    localparam int DIV_BITS    = 8;              // quotient bits per cycle
    localparam int DIV_STEPS   = VAL_W / DIV_BITS;
    localparam int STEP_W      = $clog2(DIV_STEPS);
    localparam int OFIFO_DEPTH = 4;
    localparam int OFIFO_AW    = $clog2(OFIFO_DEPTH);
    localparam int OCNT_W      = OFIFO_AW + 1;
    localparam int JOBQ_DEPTH  = 2;
    localparam int JQ_AW       = $clog2(JOBQ_DEPTH);
    localparam int JQ_CNT_W    = JQ_AW + 1;

    localparam logic [CHAR_W-1:0] CHR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHR_NINE = 8'h39;
    localparam logic [CHAR_W-1:0] CHR_A    = 8'h41;
    localparam logic [CHAR_W-1:0] CHR_F    = 8'h46;
    localparam logic [CHAR_W-1:0] CHR_NUL  = 8'h00;
    localparam logic [DIG_W-1:0]  DEC_TEN  = 4'd10;

    localparam logic [BASE_W-1:0] BASE_MIN = 5'd2;
    localparam logic [BASE_W-1:0] BASE_MAX = 5'd16;
    localparam logic [BASE_W-1:0] NO_DIGIT = 5'd16;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_ILLEGAL  = 2'd1;
    localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [CHAR_W-1:0] in_char;
        logic [BASE_W-1:0] from_base;
        logic [BASE_W-1:0] to_base;
        logic              in_last;
    } t_in_item;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              out_last;
        logic [ST_W-1:0]   status;
    } t_out_item;

    typedef enum logic [1:0] {
        JOB_ERR,
        JOB_ECHO,
        JOB_CONV
    } t_job_kind;

    typedef struct packed {
        t_job_kind         kind;
        logic [ST_W-1:0]   status;
        logic [VAL_W-1:0]  value;
        logic [BASE_W-1:0] to_base;
        logic [LEN_W-1:0]  length;
        logic              bank;
    } t_job;

    typedef enum logic [2:0] {
        B_IDLE,
        B_ERR,
        B_ECHO,
        B_DIV,
        B_EMIT
    } t_back_state;

    typedef enum logic [1:0] {
        SEL_ERR,
        SEL_SRC,
        SEL_DIG
    } t_out_sel;

    // Digit value of an ASCII character, NO_DIGIT when it is none.
    function automatic logic [BASE_W-1:0] char_value(input logic [CHAR_W-1:0] c);
        logic [BASE_W-1:0] v;
        v = NO_DIGIT;
        if (c inside {[CHR_ZERO:CHR_NINE]}) begin
            v = BASE_W'(c - CHR_ZERO);
        end else if (c inside {[CHR_A:CHR_F]}) begin
            v = BASE_W'(c - CHR_A) + BASE_W'(DEC_TEN);
        end
        return v;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIG_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DEC_TEN) begin
            c = CHR_ZERO + CHAR_W'(d);
        end else begin
            c = CHR_A + CHAR_W'(d - DEC_TEN);
        end
        return c;
    endfunction

endpackage

// ===== rtl/rcu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module rcu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/rcu_front.sv =====
// Front end: checks each character, folds it into the value, stores it for echo
// and builds one job per numeral. Depends on rcu_pkg.
module rcu_front #(
    parameter int MAX_DIGITS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  rcu_pkg::t_in_item             i_item,
    output logic                          o_wr_en,
    output logic [$clog2(MAX_DIGITS):0]   o_wr_addr,
    output logic [rcu_pkg::CHAR_W-1:0]    o_wr_data,
    output logic                          o_job_push,
    output rcu_pkg::t_job                 o_job
);

    localparam int AW   = $clog2(MAX_DIGITS);
    localparam int LW   = $clog2(MAX_DIGITS + 1);
    localparam int PW   = rcu_pkg::VAL_W + rcu_pkg::BASE_W;

    logic [LW-1:0]                 r_len, n_len;
    logic [rcu_pkg::VAL_W-1:0]     r_acc, n_acc;
    logic                          r_ill, n_ill;
    logic                          r_ovf, n_ovf;
    logic                          r_bank, n_bank;

    logic [rcu_pkg::BASE_W-1:0]    dig;
    logic                          base_bad;
    logic                          dig_bad;
    logic                          can_store;
    logic                          ill_now;
    logic                          ovf_now;
    logic                          mul_ovf;
    logic                          acc_upd;
    logic [PW-1:0]                 prod;
    logic [LW-1:0]                 len_new;
    logic [rcu_pkg::VAL_W-1:0]     acc_new;

    assign dig       = rcu_pkg::char_value(i_item.in_char);
    assign base_bad  = (i_item.from_base < rcu_pkg::BASE_MIN)
                    || (i_item.from_base > rcu_pkg::BASE_MAX)
                    || (i_item.to_base < rcu_pkg::BASE_MIN)
                    || (i_item.to_base > rcu_pkg::BASE_MAX);
    assign dig_bad   = (dig == rcu_pkg::NO_DIGIT) || (dig >= i_item.from_base);
    assign can_store = r_len < LW'(MAX_DIGITS);
    assign ill_now   = r_ill | base_bad | dig_bad;

    // acc * base + digit; anything above bit 63 is a value overflow
    assign prod    = PW'(r_acc) * PW'(i_item.from_base) + PW'(dig);
    assign mul_ovf = |prod[PW-1:rcu_pkg::VAL_W];
    assign acc_upd = !ill_now && !mul_ovf;
    assign ovf_now = r_ovf | ~can_store | (~ill_now & mul_ovf);
    assign acc_new = acc_upd ? prod[rcu_pkg::VAL_W-1:0] : r_acc;
    assign len_new = r_len + LW'(can_store);

    always_comb begin
        n_len  = r_len;
        n_acc  = r_acc;
        n_ill  = r_ill;
        n_ovf  = r_ovf;
        n_bank = r_bank;
        if (i_accept) begin
            if (i_item.in_last) begin
                // numeral done: clear and move to the other echo bank
                n_len  = '0;
                n_acc  = '0;
                n_ill  = 1'b0;
                n_ovf  = 1'b0;
                n_bank = ~r_bank;
            end else begin
                n_len  = len_new;
                n_acc  = acc_new;
                n_ill  = ill_now;
                n_ovf  = ovf_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_acc  <= '0;
            r_ill  <= 1'b0;
            r_ovf  <= 1'b0;
            r_bank <= 1'b0;
        end else begin
            r_len  <= n_len;
            r_acc  <= n_acc;
            r_ill  <= n_ill;
            r_ovf  <= n_ovf;
            r_bank <= n_bank;
        end
    end

    assign o_wr_en   = i_accept & can_store;
    assign o_wr_addr = {r_bank, r_len[AW-1:0]};
    assign o_wr_data = i_item.in_char;

    always_comb begin
        o_job_push     = i_accept & i_item.in_last;
        o_job.status   = rcu_pkg::ST_OK;
        o_job.value    = acc_new;
        o_job.to_base  = i_item.to_base;
        o_job.length   = rcu_pkg::LEN_W'(len_new);
        o_job.bank     = r_bank;
        if (ill_now) begin
            o_job.kind   = rcu_pkg::JOB_ERR;
            o_job.status = rcu_pkg::ST_ILLEGAL;
        end else if (ovf_now) begin
            o_job.kind   = rcu_pkg::JOB_ERR;
            o_job.status = rcu_pkg::ST_OVERFLOW;
        end else if (i_item.from_base == i_item.to_base) begin
            o_job.kind   = rcu_pkg::JOB_ECHO;
        end else begin
            o_job.kind   = rcu_pkg::JOB_CONV;
        end
    end

endmodule

// ===== rtl/rcu_back.sv =====
// Back end: runs one job at a time (error word, echo, or digit conversion by
// repeated division) and queues result words. Depends on rcu_pkg and rcu_ram.
module rcu_back #(
    parameter int MAX_DIGITS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_job_vld,
    input  rcu_pkg::t_job                 i_job,
    output logic                          o_job_done,
    output logic                          o_src_rd_en,
    output logic [$clog2(MAX_DIGITS):0]   o_src_rd_addr,
    input  logic [rcu_pkg::CHAR_W-1:0]    i_src_rd_data,
    output logic                          o_empty,
    input  logic                          i_pop,
    output rcu_pkg::t_out_item            o_result
);

    localparam int AW = $clog2(MAX_DIGITS);
    localparam logic [rcu_pkg::STEP_W-1:0] STEP_LAST = rcu_pkg::STEP_W'(rcu_pkg::DIV_STEPS - 1);

    rcu_pkg::t_back_state          r_state, n_state;
    logic [rcu_pkg::VAL_W-1:0]     r_val;
    logic [rcu_pkg::DIG_W-1:0]     r_rem;
    logic [rcu_pkg::BASE_W-1:0]    r_tb;
    logic [rcu_pkg::LEN_W-1:0]     r_len;
    logic                          r_bank;
    logic [rcu_pkg::ST_W-1:0]      r_status;
    logic [rcu_pkg::LEN_W-1:0]     r_idx;
    logic [rcu_pkg::LEN_W-1:0]     r_ndig;
    logic [rcu_pkg::STEP_W-1:0]    r_step;

    logic                          r_rd_vld;
    logic                          r_rd_last;
    rcu_pkg::t_out_sel             r_rd_sel;
    logic [rcu_pkg::ST_W-1:0]      r_rd_status;

    rcu_pkg::t_out_item            r_ofifo [rcu_pkg::OFIFO_DEPTH];
    logic [rcu_pkg::OFIFO_AW-1:0]  r_ohead;
    logic [rcu_pkg::OFIFO_AW-1:0]  r_otail;
    logic [rcu_pkg::OCNT_W-1:0]    r_ocnt;

    logic                          space;
    logic                          issue;
    logic                          last_echo;
    logic                          div_end;
    logic                          dig_we;
    logic                          dig_re;
    logic [rcu_pkg::DIG_W-1:0]     dig_rdata;
    logic [rcu_pkg::VAL_W-1:0]     d_val;
    logic [rcu_pkg::DIG_W-1:0]     d_rem;
    rcu_pkg::t_out_sel             issue_sel;
    logic                          push;
    logic                          pop_ok;
    rcu_pkg::t_out_item            push_item;

    // Eight restoring-division steps per cycle; remainder stays below the base.
    always_comb begin
        logic [rcu_pkg::BASE_W-1:0] t;
        d_val = r_val;
        d_rem = r_rem;
        t     = '0;
        for (int k = 0; k < rcu_pkg::DIV_BITS; k++) begin
            t     = {d_rem, d_val[rcu_pkg::VAL_W-1]};
            d_val = {d_val[rcu_pkg::VAL_W-2:0], 1'b0};
            if (t >= r_tb) begin
                t        = t - r_tb;
                d_val[0] = 1'b1;
            end
            d_rem = t[rcu_pkg::DIG_W-1:0];
        end
    end

    // Room for one more word, counting the read still in flight.
    assign space = (r_ocnt + rcu_pkg::OCNT_W'(r_rd_vld)) < rcu_pkg::OCNT_W'(rcu_pkg::OFIFO_DEPTH);
    assign last_echo = (r_idx + rcu_pkg::LEN_W'(1)) == r_len;
    assign div_end   = (r_state == rcu_pkg::B_DIV) && (r_step == STEP_LAST);

    always_comb begin
        n_state = r_state;
        case (r_state)
            rcu_pkg::B_IDLE: begin
                if (i_job_vld) begin
                    case (i_job.kind)
                        rcu_pkg::JOB_ERR:  n_state = rcu_pkg::B_ERR;
                        rcu_pkg::JOB_ECHO: n_state = rcu_pkg::B_ECHO;
                        default:           n_state = rcu_pkg::B_DIV;
                    endcase
                end
            end
            rcu_pkg::B_ERR: begin
                if (space) n_state = rcu_pkg::B_IDLE;
            end
            rcu_pkg::B_ECHO: begin
                if (space && last_echo) n_state = rcu_pkg::B_IDLE;
            end
            rcu_pkg::B_DIV: begin
                if (div_end && (d_val == '0)) n_state = rcu_pkg::B_EMIT;
            end
            rcu_pkg::B_EMIT: begin
                if (space && (r_idx == '0)) n_state = rcu_pkg::B_IDLE;
            end
            default: n_state = rcu_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        issue      = 1'b0;
        o_job_done = 1'b0;
        issue_sel  = rcu_pkg::SEL_ERR;
        case (r_state)
            rcu_pkg::B_ERR: begin
                issue      = space;
                o_job_done = space;
            end
            rcu_pkg::B_ECHO: begin
                issue      = space;
                o_job_done = space & last_echo;
                issue_sel  = rcu_pkg::SEL_SRC;
            end
            rcu_pkg::B_EMIT: begin
                issue      = space;
                o_job_done = space & (r_idx == '0);
                issue_sel  = rcu_pkg::SEL_DIG;
            end
            default: begin
                issue = 1'b0;
            end
        endcase
    end

    assign o_src_rd_en   = issue && (r_state == rcu_pkg::B_ECHO);
    assign o_src_rd_addr = {r_bank, r_idx[AW-1:0]};
    assign dig_re        = issue && (r_state == rcu_pkg::B_EMIT);
    assign dig_we        = div_end;

    rcu_ram #(
        .WIDTH (rcu_pkg::DIG_W),
        .DEPTH (rcu_pkg::DIG_DEPTH)
    ) u_dig_ram (
        .i_clk   (i_clk),
        .i_we    (dig_we),
        .i_waddr (r_ndig[rcu_pkg::DIG_AW-1:0]),
        .i_wdata (d_rem),
        .i_re    (dig_re),
        .i_raddr (r_idx[rcu_pkg::DIG_AW-1:0]),
        .o_rdata (dig_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rcu_pkg::B_IDLE;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= issue;
        end
    end

    // Job datapath: load, step the divider, walk the read index.
    always_ff @(posedge i_clk) begin
        r_rd_last   <= o_job_done;
        r_rd_sel    <= issue_sel;
        r_rd_status <= r_status;
        case (r_state)
            rcu_pkg::B_IDLE: begin
                r_val    <= i_job.value;
                r_tb     <= i_job.to_base;
                r_len    <= i_job.length;
                r_bank   <= i_job.bank;
                r_status <= i_job.status;
                r_rem    <= '0;
                r_idx    <= '0;
                r_ndig   <= '0;
                r_step   <= '0;
            end
            rcu_pkg::B_ECHO: begin
                if (issue) r_idx <= r_idx + rcu_pkg::LEN_W'(1);
            end
            rcu_pkg::B_DIV: begin
                r_val  <= d_val;
                r_step <= r_step + rcu_pkg::STEP_W'(1);
                if (div_end) begin
                    // digit complete: store it, restart on the quotient
                    r_rem  <= '0;
                    r_ndig <= r_ndig + rcu_pkg::LEN_W'(1);
                    r_idx  <= r_ndig;
                end else begin
                    r_rem  <= d_rem;
                end
            end
            rcu_pkg::B_EMIT: begin
                if (issue) r_idx <= r_idx - rcu_pkg::LEN_W'(1);
            end
            default: begin
                r_idx <= r_idx;
            end
        endcase
    end

    always_comb begin
        push_item.out_last = r_rd_last;
        push_item.status   = rcu_pkg::ST_OK;
        case (r_rd_sel)
            rcu_pkg::SEL_SRC: push_item.out_char = i_src_rd_data;
            rcu_pkg::SEL_DIG: push_item.out_char = rcu_pkg::digit_char(dig_rdata);
            default: begin
                push_item.out_char = rcu_pkg::CHR_NUL;
                push_item.status   = r_rd_status;
            end
        endcase
    end

    assign push     = r_rd_vld;
    assign pop_ok   = i_pop & ~o_empty;
    assign o_empty  = (r_ocnt == '0);
    assign o_result = r_ofifo[r_ohead];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_ofifo[r_otail] <= push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ohead <= '0;
            r_otail <= '0;
            r_ocnt  <= '0;
        end else begin
            if (push)   r_otail <= r_otail + rcu_pkg::OFIFO_AW'(1);
            if (pop_ok) r_ohead <= r_ohead + rcu_pkg::OFIFO_AW'(1);
            r_ocnt <= r_ocnt + rcu_pkg::OCNT_W'(push) - rcu_pkg::OCNT_W'(pop_ok);
        end
    end

    a_div_base_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rcu_pkg::B_DIV) |-> (r_tb >= rcu_pkg::BASE_MIN && r_tb <= rcu_pkg::BASE_MAX))
        else $error("divider running with a base outside 2..16");

    a_ndig_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ndig <= rcu_pkg::LEN_W'(rcu_pkg::DIG_DEPTH))
        else $error("digit count beyond digit store");

    a_ofifo_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (r_ocnt < rcu_pkg::OCNT_W'(rcu_pkg::OFIFO_DEPTH) || pop_ok))
        else $error("result queue overflow");

endmodule

// ===== rtl/radix_converter_unit.sv =====
// Top level of the radix converter: front end, job queue, echo store, back end.
// Depends on rcu_pkg, rcu_ram, rcu_front and rcu_back.
//
// Usage:
//   Input channel: drive i_item and raise push; a character is taken on a clock
//   edge with push high and full low. Send a numeral most significant character
//   first and mark its final character with in_last.
//   Result channel: while empty is low, o_result holds the oldest result word;
//   it is taken on an edge with pop high. Each numeral gives one or more words,
//   the last one flagged out_last; an error gives one word with out_char 0.
//   Timing: while full is low the front end takes one character per cycle; the
//   final character hands a job to a two-entry queue. With the back end idle, an
//   error word or the echo words follow the final character, one word per cycle
//   while the result queue has room. A conversion runs the divider at 8 quotient
//   bits a cycle once per target digit, then emits the digits one per cycle while
//   the result queue has room. The front end keeps taking the next numeral while
//   the back end works; full rises only while two jobs are queued.
//   A stalled receiver backs up a four-word result queue, then the back end,
//   then the job queue, then push. Reset clears all control state at once; no
//   clearing pass is needed and the block is ready the cycle after reset.
module radix_converter_unit #(
    parameter int MAX_DIGITS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  rcu_pkg::t_in_item  i_item,
    output logic               empty,
    input  logic               pop,
    output rcu_pkg::t_out_item o_result
);

    localparam int SAW = $clog2(MAX_DIGITS) + 1;   // two banks of echo storage

    logic                          accept;
    logic                          src_we;
    logic [SAW-1:0]                src_waddr;
    logic [rcu_pkg::CHAR_W-1:0]    src_wdata;
    logic                          src_re;
    logic [SAW-1:0]                src_raddr;
    logic [rcu_pkg::CHAR_W-1:0]    src_rdata;
    logic                          job_push;
    rcu_pkg::t_job                 job_in;
    logic                          job_done;

    rcu_pkg::t_job                 r_jq [rcu_pkg::JOBQ_DEPTH];
    logic [rcu_pkg::JQ_AW-1:0]     r_jhead;
    logic [rcu_pkg::JQ_AW-1:0]     r_jtail;
    logic [rcu_pkg::JQ_CNT_W-1:0]  r_jcnt;

    // The job at the head stays queued until the back end finishes it, so a
    // full queue also guards the echo bank that the head job still reads.
    assign full   = (r_jcnt == rcu_pkg::JQ_CNT_W'(rcu_pkg::JOBQ_DEPTH));
    assign accept = push & ~full;

    rcu_front #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (i_item),
        .o_wr_en    (src_we),
        .o_wr_addr  (src_waddr),
        .o_wr_data  (src_wdata),
        .o_job_push (job_push),
        .o_job      (job_in)
    );

    rcu_ram #(
        .WIDTH (rcu_pkg::CHAR_W),
        .DEPTH (2 ** SAW)
    ) u_src_ram (
        .i_clk   (i_clk),
        .i_we    (src_we),
        .i_waddr (src_waddr),
        .i_wdata (src_wdata),
        .i_re    (src_re),
        .i_raddr (src_raddr),
        .o_rdata (src_rdata)
    );

    // Hold jobs between the two halves.
    always_ff @(posedge i_clk) begin
        if (job_push) begin
            r_jq[r_jtail] <= job_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jhead <= '0;
            r_jtail <= '0;
            r_jcnt  <= '0;
        end else begin
            if (job_push) r_jtail <= r_jtail + rcu_pkg::JQ_AW'(1);
            if (job_done) r_jhead <= r_jhead + rcu_pkg::JQ_AW'(1);
            r_jcnt <= r_jcnt + rcu_pkg::JQ_CNT_W'(job_push) - rcu_pkg::JQ_CNT_W'(job_done);
        end
    end

    rcu_back #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_vld     (r_jcnt != '0),
        .i_job         (r_jq[r_jhead]),
        .o_job_done    (job_done),
        .o_src_rd_en   (src_re),
        .o_src_rd_addr (src_raddr),
        .i_src_rd_data (src_rdata),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_result      (o_result)
    );

    a_jq_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_push |-> (r_jcnt < rcu_pkg::JQ_CNT_W'(rcu_pkg::JOBQ_DEPTH)))
        else $error("job pushed into a full queue");

    a_jq_done_has_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_done |-> (r_jcnt != '0))
        else $error("job finished with the queue empty");

    a_jq_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_jcnt <= rcu_pkg::JQ_CNT_W'(rcu_pkg::JOBQ_DEPTH))
        else $error("job queue count out of range");

endmodule
